// ===== rtl/rgbyc_pkg.sv =====
`timescale 1ns / 1ps

package rgbyc_pkg;

  localparam int unsigned AddrW  = 21;
  localparam int unsigned IdxW   = 14;
  localparam int unsigned ProdW  = 24;
  localparam int unsigned SumW   = 26;

  localparam logic [6:0]  CfgReset = 7'd50;

  localparam logic [15:0] YrCoef  = 16'd19595;
  localparam logic [15:0] YgCoef  = 16'd38470;
  localparam logic [15:0] YbCoef  = 16'd7471;
  localparam logic [15:0] CbrCoef = 16'd11056;
  localparam logic [15:0] CbgCoef = 16'd21712;
  localparam logic [15:0] CbbCoef = 16'd32768;
  localparam logic [15:0] CrrCoef = 16'd32768;
  localparam logic [15:0] CrgCoef = 16'd27440;
  localparam logic [15:0] CrbCoef = 16'd5328;

  localparam logic [SumW-1:0] ChromaBias = SumW'(8388608);

  localparam logic [AddrW-1:0] CbOffset = AddrW'(256);
  localparam logic [AddrW-1:0] CrOffset = AddrW'(320);

  typedef struct packed {
    logic [7:0]      r;
    logic [7:0]      g;
    logic [7:0]      b;
    logic [IdxW-1:0] idx;
    logic [7:0]      loff;
    logic [5:0]      coff;
    logic            chroma;
  } s1_t;

  typedef struct packed {
    logic [AddrW-1:0] base;
    logic [7:0]       loff;
    logic [5:0]       coff;
    logic             chroma;
    logic [ProdW-1:0] yr;
    logic [ProdW-1:0] yg;
    logic [ProdW-1:0] yb;
    logic [ProdW-1:0] cbr;
    logic [ProdW-1:0] cbg;
    logic [ProdW-1:0] cbb;
    logic [ProdW-1:0] crr;
    logic [ProdW-1:0] crg;
    logic [ProdW-1:0] crb;
  } s2_t;

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  function automatic logic [7:0] clamp_byte(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] sh;
    sh = v >>> 16;
    if (sh < 0) return 8'd0;
    if (sh > 255) return 8'd255;
    return sh[7:0];
  endfunction

endpackage

// ===== rtl/rgb565_to_ycbcr420_mcu.sv =====
`timescale 1ns / 1ps

// Channel  Handshake                Payload
// cfg      cfg_valid_i/cfg_ready_o  cfg_data_i (mcus_per_row)
// in       in_valid_i/in_ready_o    pixel, pixel_column/row, mcu_column/row
// out      out_valid_o/out_ready_i  y, cb, cr addresses and values, chroma_valid
//
// One beat per cycle sustained while out_ready_i is high; registered stages: prep, multiply, sum/clamp.
// Each stage holds a valid bit; a stage loads when it is empty or drains.
// Reset clears the valid bits and loads mcus_per_row with 50.
// A stall at the output backs up stage by stage; bubbles are squeezed out.

module rgb565_to_ycbcr420_mcu import rgbyc_pkg::*; #(
  parameter int unsigned MAX_MCUS_PER_ROW = 64,
  parameter int unsigned MAX_MCU_ROWS     = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [6:0]       cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [15:0]      pixel_i,
  input  logic [3:0]       pixel_column_i,
  input  logic [3:0]       pixel_row_i,
  input  logic [5:0]       mcu_column_i,
  input  logic [5:0]       mcu_row_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [AddrW-1:0] y_address_o,
  output logic [7:0]       y_value_o,
  output logic             chroma_valid_o,
  output logic [AddrW-1:0] cb_address_o,
  output logic [7:0]       cb_value_o,
  output logic [AddrW-1:0] cr_address_o,
  output logic [7:0]       cr_value_o
);

  logic [6:0] per_row_q;
  logic       s1_valid, s1_ready, s2_valid, s2_ready;
  s1_t        s1_data;
  s2_t        s2_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      per_row_q <= CfgReset;
    end else if (cfg_valid_i) begin
      per_row_q <= cfg_data_i;
    end
  end

  rgbyc_prep #(
    .MAX_MCUS_PER_ROW(MAX_MCUS_PER_ROW),
    .MAX_MCU_ROWS    (MAX_MCU_ROWS)
  ) u_prep (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mcus_per_row_i(per_row_q),
    .valid_i       (in_valid_i),
    .ready_o       (in_ready_o),
    .pixel_i       (pixel_i),
    .pixel_column_i(pixel_column_i),
    .pixel_row_i   (pixel_row_i),
    .mcu_column_i  (mcu_column_i),
    .mcu_row_i     (mcu_row_i),
    .valid_o       (s1_valid),
    .ready_i       (s1_ready),
    .data_o        (s1_data)
  );

  rgbyc_mult u_mult (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s1_valid),
    .ready_o(s1_ready),
    .data_i (s1_data),
    .valid_o(s2_valid),
    .ready_i(s2_ready),
    .data_o (s2_data)
  );

  rgbyc_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (s2_valid),
    .ready_o       (s2_ready),
    .data_i        (s2_data),
    .valid_o       (out_valid_o),
    .ready_i       (out_ready_i),
    .y_address_o   (y_address_o),
    .y_value_o     (y_value_o),
    .chroma_valid_o(chroma_valid_o),
    .cb_address_o  (cb_address_o),
    .cb_value_o    (cb_value_o),
    .cr_address_o  (cr_address_o),
    .cr_value_o    (cr_value_o)
  );

endmodule

// ===== rtl/rgbyc_prep.sv =====
`timescale 1ns / 1ps

module rgbyc_prep import rgbyc_pkg::*; #(
  parameter int unsigned MAX_MCUS_PER_ROW = 64,
  parameter int unsigned MAX_MCU_ROWS     = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [6:0]  mcus_per_row_i,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [15:0] pixel_i,
  input  logic [3:0]  pixel_column_i,
  input  logic [3:0]  pixel_row_i,
  input  logic [5:0]  mcu_column_i,
  input  logic [5:0]  mcu_row_i,
  output logic        valid_o,
  input  logic        ready_i,
  output s1_t         data_o
);

  localparam logic [8:0] PerRowMax = 9'(MAX_MCUS_PER_ROW);
  localparam logic [8:0] ColMax    = 9'(MAX_MCUS_PER_ROW - 1);
  localparam logic [8:0] RowMax    = 9'(MAX_MCU_ROWS - 1);

  logic       valid_q;
  s1_t        data_q, data_d;
  logic [6:0] per_row;
  logic [5:0] mcol, mrow;

  always_comb begin
    per_row = ({2'b00, mcus_per_row_i} > PerRowMax) ? PerRowMax[6:0] : mcus_per_row_i;
    mcol    = ({3'b000, mcu_column_i} > ColMax) ? ColMax[5:0] : mcu_column_i;
    mrow    = ({3'b000, mcu_row_i} > RowMax) ? RowMax[5:0] : mcu_row_i;
    data_d.r      = widen5(pixel_i[15:11]);
    data_d.g      = widen6(pixel_i[10:5]);
    data_d.b      = widen5(pixel_i[4:0]);
    data_d.idx    = IdxW'(mrow) * IdxW'(per_row) + IdxW'(mcol);
    data_d.loff   = {pixel_row_i[3], pixel_column_i[3], pixel_row_i[2:0], pixel_column_i[2:0]};
    data_d.coff   = {pixel_row_i[3:1], pixel_column_i[3:1]};
    data_d.chroma = ~(pixel_row_i[0] | pixel_column_i[0]);
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/rgbyc_mult.sv =====
`timescale 1ns / 1ps

module rgbyc_mult import rgbyc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  s1_t  data_i,
  output logic valid_o,
  input  logic ready_i,
  output s2_t  data_o
);

  logic valid_q;
  s2_t  data_q, data_d;

  always_comb begin
    data_d.base   = AddrW'({data_i.idx, 8'd0} + {1'b0, data_i.idx, 7'd0});
    data_d.loff   = data_i.loff;
    data_d.coff   = data_i.coff;
    data_d.chroma = data_i.chroma;
    data_d.yr     = data_i.r * YrCoef;
    data_d.yg     = data_i.g * YgCoef;
    data_d.yb     = data_i.b * YbCoef;
    data_d.cbr    = data_i.r * CbrCoef;
    data_d.cbg    = data_i.g * CbgCoef;
    data_d.cbb    = data_i.b * CbbCoef;
    data_d.crr    = data_i.r * CrrCoef;
    data_d.crg    = data_i.g * CrgCoef;
    data_d.crb    = data_i.b * CrbCoef;
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/rgbyc_out.sv =====
`timescale 1ns / 1ps

module rgbyc_out import rgbyc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  s2_t              data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [AddrW-1:0] y_address_o,
  output logic [7:0]       y_value_o,
  output logic             chroma_valid_o,
  output logic [AddrW-1:0] cb_address_o,
  output logic [7:0]       cb_value_o,
  output logic [AddrW-1:0] cr_address_o,
  output logic [7:0]       cr_value_o
);

  logic                   valid_q;
  logic [AddrW-1:0]       y_addr_q, cb_addr_q, cr_addr_q;
  logic [AddrW-1:0]       y_addr_d, cb_addr_d, cr_addr_d;
  logic [7:0]             y_val_q, cb_val_q, cr_val_q;
  logic [7:0]             y_val_d, cb_val_d, cr_val_d;
  logic                   chroma_q;
  logic signed [SumW-1:0] y_sum, cb_sum, cr_sum;

  always_comb begin
    y_sum  = $signed(SumW'(data_i.yr) + SumW'(data_i.yg) + SumW'(data_i.yb));
    cb_sum = $signed(ChromaBias + SumW'(data_i.cbb) - SumW'(data_i.cbr) - SumW'(data_i.cbg));
    cr_sum = $signed(ChromaBias + SumW'(data_i.crr) - SumW'(data_i.crg) - SumW'(data_i.crb));
    y_addr_d  = data_i.base + AddrW'(data_i.loff);
    y_val_d   = clamp_byte(y_sum);
    cb_addr_d = '0;
    cr_addr_d = '0;
    cb_val_d  = '0;
    cr_val_d  = '0;
    if (data_i.chroma) begin
      cb_addr_d = data_i.base + CbOffset + AddrW'(data_i.coff);
      cr_addr_d = data_i.base + CrOffset + AddrW'(data_i.coff);
      cb_val_d  = clamp_byte(cb_sum);
      cr_val_d  = clamp_byte(cr_sum);
    end
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      y_addr_q  <= y_addr_d;
      y_val_q   <= y_val_d;
      chroma_q  <= data_i.chroma;
      cb_addr_q <= cb_addr_d;
      cb_val_q  <= cb_val_d;
      cr_addr_q <= cr_addr_d;
      cr_val_q  <= cr_val_d;
    end
  end

  assign valid_o        = valid_q;
  assign y_address_o    = y_addr_q;
  assign y_value_o      = y_val_q;
  assign chroma_valid_o = chroma_q;
  assign cb_address_o   = cb_addr_q;
  assign cb_value_o     = cb_val_q;
  assign cr_address_o   = cr_addr_q;
  assign cr_value_o     = cr_val_q;

endmodule

// ===== dv/ycbcr_sample_checker.sv =====
`timescale 1ns / 1ps

module ycbcr_sample_checker import rgbyc_pkg::*; #(
  parameter int unsigned MAX_MCUS_PER_ROW = 64,
  parameter int unsigned MAX_MCU_ROWS     = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [6:0]       cfg_data_i,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [15:0]      pixel_i,
  input  logic [3:0]       pixel_column_i,
  input  logic [3:0]       pixel_row_i,
  input  logic [5:0]       mcu_column_i,
  input  logic [5:0]       mcu_row_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [AddrW-1:0] y_address_i,
  input  logic [7:0]       y_value_i,
  input  logic             chroma_valid_i,
  input  logic [AddrW-1:0] cb_address_i,
  input  logic [7:0]       cb_value_i,
  input  logic [AddrW-1:0] cr_address_i,
  input  logic [7:0]       cr_value_i,
  output int               fails_o,
  output int               pending_o
);

  typedef struct packed {
    logic [AddrW-1:0] y_addr;
    logic [7:0]       y_val;
    logic             chroma;
    logic [AddrW-1:0] cb_addr;
    logic [7:0]       cb_val;
    logic [AddrW-1:0] cr_addr;
    logic [7:0]       cr_val;
  } mcu_sample_t;

  mcu_sample_t expected_samples[$];
  logic [6:0]  mcus_per_row_q;

  initial begin
    fails_o   = 0;
    pending_o = 0;
  end

  // floor(sum / 65536) + 128, clamped to a byte
  function automatic logic [7:0] chroma_byte(input int sum);
    int biased;
    int q;
    biased = sum + 8388608;
    if (biased < 0) return 8'd0;
    q = biased >>> 16;
    if (q > 255) return 8'd255;
    return q[7:0];
  endfunction

  function automatic mcu_sample_t mcu_sample_of(input logic [15:0] pix,
                                                input logic [3:0]  col,
                                                input logic [3:0]  row,
                                                input logic [5:0]  mcol,
                                                input logic [5:0]  mrow,
                                                input logic [6:0]  per_row_reg);
    logic [7:0]  r8, g8, b8;
    int          ri, gi, bi;
    int unsigned per_row, mc, mr, base, offs, luma;
    mcu_sample_t s;
    r8 = {pix[15:11], pix[15:13]};
    g8 = {pix[10:5], pix[10:9]};
    b8 = {pix[4:0], pix[4:2]};
    ri = r8;
    gi = g8;
    bi = b8;
    per_row = (per_row_reg > MAX_MCUS_PER_ROW) ? MAX_MCUS_PER_ROW : per_row_reg;
    mc = (mcol > MAX_MCUS_PER_ROW - 1) ? MAX_MCUS_PER_ROW - 1 : mcol;
    mr = (mrow > MAX_MCU_ROWS - 1) ? MAX_MCU_ROWS - 1 : mrow;
    base = (mr * per_row + mc) * 384;
    s = '0;
    s.y_addr = AddrW'(base + {row[3], col[3]} * 64 + row[2:0] * 8 + col[2:0]);
    luma = (19595 * ri + 38470 * gi + 7471 * bi) >> 16;
    s.y_val = (luma > 255) ? 8'd255 : luma[7:0];
    if (!row[0] && !col[0]) begin
      offs = row[3:1] * 8 + col[3:1];
      s.chroma  = 1'b1;
      s.cb_addr = AddrW'(base + 256 + offs);
      s.cr_addr = AddrW'(base + 320 + offs);
      s.cb_val  = chroma_byte(-11056 * ri - 21712 * gi + 32768 * bi);
      s.cr_val  = chroma_byte(32768 * ri - 27440 * gi - 5328 * bi);
    end
    return s;
  endfunction

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      fails_o++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    mcu_sample_t want;
    if (!rst_ni) begin
      mcus_per_row_q = CfgReset;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_samples.size() == 0) begin
          fails_o++;
          $display("%0t: unexpected beat, expected none, got y_address 0x%0h",
                   $time, y_address_i);
        end else begin
          want = expected_samples.pop_front();
          compare_field("y_address", want.y_addr, y_address_i);
          compare_field("y_value", want.y_val, y_value_i);
          compare_field("chroma_valid", want.chroma, chroma_valid_i);
          compare_field("cb_address", want.cb_addr, cb_address_i);
          compare_field("cb_value", want.cb_val, cb_value_i);
          compare_field("cr_address", want.cr_addr, cr_address_i);
          compare_field("cr_value", want.cr_val, cr_value_i);
        end
      end
      if (in_valid_i && in_ready_i)
        expected_samples.push_back(mcu_sample_of(pixel_i, pixel_column_i, pixel_row_i,
                                                 mcu_column_i, mcu_row_i, mcus_per_row_q));
      if (cfg_valid_i && cfg_ready_i) mcus_per_row_q = cfg_data_i;
    end
    pending_o = expected_samples.size();
  end

endmodule

// ===== dv/tb_rgb565_to_ycbcr420_mcu.sv =====
`timescale 1ns / 1ps

module tb_rgb565_to_ycbcr420_mcu import rgbyc_pkg::*;;

  logic             clk_i;
  logic             rst_ni         = 1'b0;
  logic             cfg_valid_i    = 1'b0;
  logic             cfg_ready_o;
  logic [6:0]       cfg_data_i     = '0;
  logic             in_valid_i     = 1'b0;
  logic             in_ready_o;
  logic [15:0]      pixel_i        = '0;
  logic [3:0]       pixel_column_i = '0;
  logic [3:0]       pixel_row_i    = '0;
  logic [5:0]       mcu_column_i   = '0;
  logic [5:0]       mcu_row_i      = '0;
  logic             out_valid_o;
  logic             out_ready_i    = 1'b0;
  logic [AddrW-1:0] y_address_o;
  logic [7:0]       y_value_o;
  logic             chroma_valid_o;
  logic [AddrW-1:0] cb_address_o;
  logic [7:0]       cb_value_o;
  logic [AddrW-1:0] cr_address_o;
  logic [7:0]       cr_value_o;

  int fails;
  int pending;
  int idle_pct  = 0;
  int stall_pct = 0;

  rgb565_to_ycbcr420_mcu #(
    .MAX_MCUS_PER_ROW(64),
    .MAX_MCU_ROWS    (64)
  ) uut (.*);

  ycbcr_sample_checker #(
    .MAX_MCUS_PER_ROW(64),
    .MAX_MCU_ROWS    (64)
  ) checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .pixel_i       (pixel_i),
    .pixel_column_i(pixel_column_i),
    .pixel_row_i   (pixel_row_i),
    .mcu_column_i  (mcu_column_i),
    .mcu_row_i     (mcu_row_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .y_address_i   (y_address_o),
    .y_value_i     (y_value_o),
    .chroma_valid_i(chroma_valid_o),
    .cb_address_i  (cb_address_o),
    .cb_value_i    (cb_value_o),
    .cr_address_i  (cr_address_o),
    .cr_value_i    (cr_value_o),
    .fails_o       (fails),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= stall_pct);

  // entered and left at a falling edge; a held beat is dropped or replaced by the caller
  task automatic send_pixel(input logic [15:0] pix, input logic [3:0] col,
                            input logic [3:0] row, input logic [5:0] mcol,
                            input logic [5:0] mrow);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    pixel_i        <= pix;
    pixel_column_i <= col;
    pixel_row_i    <= row;
    mcu_column_i   <= mcol;
    mcu_row_i      <= mrow;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic send_random_pixel();
    logic [15:0] pix;
    case ($urandom_range(7))
      0:       pix = 16'h0000;
      1:       pix = 16'hFFFF;
      default: pix = 16'($urandom);
    endcase
    send_pixel(pix, 4'($urandom_range(15)), 4'($urandom_range(15)),
               6'($urandom_range(63)), 6'($urandom_range(63)));
  endtask

  task automatic write_mcus_per_row(input logic [6:0] value);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [6:0] setting;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: color extremes, chroma on/off positions, MCU corners
    send_pixel(16'h0000, 4'd0, 4'd0, 6'd0, 6'd0);
    send_pixel(16'hFFFF, 4'd15, 4'd15, 6'd63, 6'd63);
    send_pixel(16'hFFFF, 4'd14, 4'd14, 6'd63, 6'd63);
    send_pixel(16'hF800, 4'd0, 4'd0, 6'd1, 6'd0);
    send_pixel(16'h07E0, 4'd2, 4'd0, 6'd0, 6'd1);
    send_pixel(16'h001F, 4'd0, 4'd2, 6'd49, 6'd0);
    send_pixel(16'hFFE0, 4'd8, 4'd8, 6'd50, 6'd2);
    send_pixel(16'h07FF, 4'd6, 4'd8, 6'd10, 6'd10);
    send_pixel(16'hF81F, 4'd8, 4'd6, 6'd3, 6'd7);
    send_pixel(16'h8410, 4'd1, 4'd0, 6'd0, 6'd0);
    send_pixel(16'h7BEF, 4'd0, 4'd1, 6'd0, 6'd0);
    send_pixel(16'hF800, 4'd7, 4'd7, 6'd63, 6'd0);
    send_pixel(16'h001F, 4'd15, 4'd0, 6'd0, 6'd63);
    send_pixel(16'h07E0, 4'd0, 4'd15, 6'd32, 6'd32);
    send_pixel(16'hFFE0, 4'd9, 4'd9, 6'd21, 6'd42);
    send_pixel(16'h07FF, 4'd14, 4'd0, 6'd42, 6'd21);
    send_pixel(16'h0821, 4'd0, 4'd14, 6'd1, 6'd1);
    send_pixel(16'hF7DE, 4'd4, 4'd12, 6'd60, 6'd60);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       setting = 7'd0;
        1:       setting = 7'd1;
        2:       setting = 7'd64;
        3:       setting = 7'd127;
        4:       setting = 7'd65;
        5:       setting = 7'd50;
        6:       setting = 7'($urandom_range(63, 2));
        default: setting = 7'($urandom_range(127));
      endcase
      write_mcus_per_row(setting);
      case (p % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 86;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 86;
        end
        default: begin
          idle_pct  = 12;
          stall_pct = 12;
        end
      endcase
      repeat (54) send_random_pixel();
    end

    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d beats outstanding", pending);
    $display("Some tests failed");
    $finish;
  end

endmodule
